// ===== rtl/ccm_pkg.sv =====
`default_nettype none

package ccm_pkg;

  // widths of the stream fields
  localparam int unsigned POWER_W    = 3;
  localparam int unsigned OFFSET_W   = 32;
  localparam int unsigned SIZE_W     = 31;
  localparam int unsigned MOMENT_W   = 32;
  localparam int unsigned WORD_W     = 64;
  localparam int unsigned IN_TDATA_W = 112;   // 105 bits of fields, padded to 14 bytes
  localparam int unsigned CFG_IDX_W  = 2;

  // defaults for the top-level parameters
  localparam int unsigned MAX_DEGREE_DEF = 4;
  localparam int unsigned DIV_W_DEF      = 7; // holds (MAX_DEGREE_DEF+1)^3

  // Q16.16 one and the 64-bit signed ends
  localparam logic [WORD_W-1:0] Q_ONE    = 64'h0000_0000_0001_0000;
  localparam logic [WORD_W-1:0] WORD_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [WORD_W-1:0] WORD_MIN = 64'h8000_0000_0000_0000;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE_Z = 2'd2;

  // status from an arithmetic unit: done pulses, clip holds until next run
  typedef struct packed {
    logic done;
    logic clip;
  } stat_t;

endpackage

`default_nettype wire

// ===== rtl/ccm_mul.sv =====
`default_nettype none

// Q16.16 x Q16.16 -> Q16.16 on 64-bit words, one 32x32 partial product a cycle.
// Magnitude rounded half away from zero, saturated to signed 64 bits.
module ccm_mul import ccm_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [WORD_W-1:0] op_a,
  input  logic signed [WORD_W-1:0] op_b,
  output logic signed [WORD_W-1:0] product,
  output stat_t                    stat
);

  typedef enum logic [1:0] {M_IDLE, M_RUN, M_FIN} mstate_t;

  mstate_t             state;
  logic [WORD_W-1:0]   mag_a;
  logic [WORD_W-1:0]   mag_b;
  logic                neg;
  logic [2*WORD_W-1:0] acc;
  logic [WORD_W-1:0]   pp;
  logic [1:0]          pp_sh;
  logic [2:0]          cnt;

  logic [31:0]         mul_x;
  logic [31:0]         mul_y;
  logic [1:0]          sh_next;
  logic [2*WORD_W-1:0] pp_wide;
  logic [WORD_W-1:0]   rlo;
  logic                over;

  always_comb begin
    case (cnt[1:0])
      2'd0: begin
        mul_x = mag_a[31:0];  mul_y = mag_b[31:0];  sh_next = 2'd0;
      end
      2'd1: begin
        mul_x = mag_a[31:0];  mul_y = mag_b[63:32]; sh_next = 2'd1;
      end
      2'd2: begin
        mul_x = mag_a[63:32]; mul_y = mag_b[31:0];  sh_next = 2'd1;
      end
      default: begin
        mul_x = mag_a[63:32]; mul_y = mag_b[63:32]; sh_next = 2'd2;
      end
    endcase
    case (pp_sh)
      2'd0:    pp_wide = {64'd0, pp};
      2'd1:    pp_wide = {32'd0, pp, 32'd0};
      default: pp_wide = {pp, 64'd0};
    endcase
    rlo  = acc[79:16];
    over = (acc[127:80] != 48'd0) || (rlo > (neg ? WORD_MIN : WORD_MAX));
  end

  always_ff @(posedge clk) begin
    stat.done <= !rst && (state == M_FIN);
    if (rst) begin
      state <= M_IDLE;
    end else begin
      case (state)
        M_IDLE: begin
          if (start) begin
            mag_a <= op_a[WORD_W-1] ? WORD_W'(-op_a) : op_a;
            mag_b <= op_b[WORD_W-1] ? WORD_W'(-op_b) : op_b;
            neg   <= op_a[WORD_W-1] ^ op_b[WORD_W-1];
            acc   <= 128'h8000;     // rounding half folded in up front
            cnt   <= 3'd0;
            state <= M_RUN;
          end
        end
        M_RUN: begin
          if (cnt != 3'd4) begin
            pp    <= WORD_W'(mul_x) * WORD_W'(mul_y);
            pp_sh <= sh_next;
          end
          if (cnt != 3'd0) acc <= acc + pp_wide;
          if (cnt == 3'd4) state <= M_FIN;
          cnt <= cnt + 3'd1;
        end
        M_FIN: begin
          if (over) begin
            product <= neg ? WORD_MIN : WORD_MAX;
          end else begin
            product <= neg ? WORD_W'(-rlo) : rlo;
          end
          stat.clip <= over;
          state     <= M_IDLE;
        end
        default: state <= M_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ccm_div.sv =====
`default_nettype none

// Signed 64-bit by small unsigned divisor, rounded half away from zero,
// restoring one bit a cycle, quotient saturated to signed 32 bits.
module ccm_div import ccm_pkg::*; #(
  parameter int unsigned DIV_W = DIV_W_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [WORD_W-1:0] dividend,
  input  logic [DIV_W-1:0]         divisor,
  output logic [MOMENT_W-1:0]      quot,
  output stat_t                    stat
);

  typedef enum logic [1:0] {D_IDLE, D_RND, D_RUN, D_FIN} dstate_t;

  dstate_t           state;
  logic [WORD_W-1:0] num;        // numerator, becomes the quotient
  logic [DIV_W-1:0]  dvs;
  logic [DIV_W-1:0]  rem;
  logic              neg;
  logic [5:0]        cnt;

  logic [DIV_W:0]    trial;
  logic              qbit;
  logic [DIV_W:0]    trial_sub;

  always_comb begin
    trial     = {rem, num[WORD_W-1]};
    trial_sub = trial - {1'b0, dvs};
    qbit      = (trial >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    stat.done <= !rst && (state == D_FIN);
    if (rst) begin
      state <= D_IDLE;
    end else begin
      case (state)
        D_IDLE: begin
          if (start) begin
            num   <= dividend[WORD_W-1] ? WORD_W'(-dividend) : dividend;
            neg   <= dividend[WORD_W-1];
            dvs   <= divisor;
            rem   <= '0;
            cnt   <= 6'd0;
            state <= D_RND;
          end
        end
        D_RND: begin
          num   <= num + WORD_W'(dvs >> 1);
          state <= D_RUN;
        end
        D_RUN: begin
          rem <= qbit ? DIV_W'(trial_sub) : DIV_W'(trial);
          num <= {num[WORD_W-2:0], qbit};
          if (cnt == 6'd63) state <= D_FIN;
          cnt <= cnt + 6'd1;
        end
        D_FIN: begin
          if (neg) begin
            stat.clip <= (num > 64'h8000_0000);
            quot      <= (num > 64'h8000_0000) ? 32'h8000_0000 : MOMENT_W'(-num);
          end else begin
            stat.clip <= (num > 64'h7FFF_FFFF);
            quot      <= (num > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : num[MOMENT_W-1:0];
          end
          state <= D_IDLE;
        end
        default: state <= D_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/cartesian_cell_moment_unit.sv =====
`default_nettype none

// Cell-average monomial moment of one Cartesian cell, signed Q16.16 in and out.
// Each item carries three degrees (clamped to MAX_DEGREE) and three centre
// offsets; cell sizes come from the configuration port (reset value 1.0). Per
// axis the unit forms the ends a = h/2 + d and b = d - h/2, builds the powers
// a^k and b^k, sums a^(p-m) b^m for m = 0..p, multiplies the three sums and
// divides by (px+1)(py+1)(pz+1), rounding half away from zero. All products go
// through one shared 64-bit multiplier that takes one 32x32 partial product a
// cycle; the final divide is a restoring divider at one bit a cycle.
// s_axis_tready is high only while the sequencer is idle; the finished item
// sits in the output register, so the next item can be taken while it waits.
// m_axis_tuser flags any clipping, whether in a 64-bit intermediate or in the
// final 32-bit result. The configuration port is always ready and must only be
// written while the unit is idle.
module cartesian_cell_moment_unit import ccm_pkg::*; #(
  parameter int unsigned MAX_DEGREE = MAX_DEGREE_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // input items
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // power_x[2:0], power_y[5:3], power_z[8:6], offset_x[40:9],
  // offset_y[72:41], offset_z[104:73], zero pad [111:105]
  input  logic [IN_TDATA_W-1:0] s_axis_tdata,
  // results
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // moment[31:0]
  output logic [MOMENT_W-1:0]   m_axis_tdata,
  // saturated[0]
  output logic [0:0]            m_axis_tuser,
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [SIZE_W-1:0]     cfg_data
);

  localparam int unsigned IDX_W = (MAX_DEGREE < 1) ? 1 : $clog2(MAX_DEGREE + 1);
  localparam int unsigned DIV_W = $clog2((MAX_DEGREE + 1) ** 3 + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_AXIS, S_POWA, S_POWB, S_CROSS, S_MWAIT,
    S_PXY, S_PZ, S_DIV, S_DWAIT, S_OUT
  } state_t;

  typedef enum logic [2:0] {OP_POWA, OP_POWB, OP_CROSS, OP_PXY, OP_PZ} op_t;

  function automatic logic [POWER_W-1:0] clamp_deg(input logic [POWER_W-1:0] v);
    logic [POWER_W-1:0] r;
    r = (int'(v) > MAX_DEGREE) ? POWER_W'(MAX_DEGREE) : v;
    return r;
  endfunction

  // configuration
  logic [SIZE_W-1:0] size_x;
  logic [SIZE_W-1:0] size_y;
  logic [SIZE_W-1:0] size_z;

  // item fields
  logic [POWER_W-1:0]         pw_x, pw_y, pw_z;
  logic signed [OFFSET_W-1:0] off_x, off_y, off_z;
  logic [DIV_W-1:0]           divisor;

  // sequencer
  state_t                   state;
  op_t                      op;
  logic [1:0]               axis;
  logic [IDX_W-1:0]         k;
  logic [IDX_W-1:0]         m;
  logic                     clip;
  logic signed [WORD_W-1:0] a_end, b_end;
  logic signed [WORD_W-1:0] pa [0:MAX_DEGREE];   // a^k
  logic signed [WORD_W-1:0] pb [0:MAX_DEGREE];   // b^k
  logic signed [WORD_W-1:0] sum;                 // running axis sum, z sum at the end
  logic signed [WORD_W-1:0] sx, sy;
  logic signed [WORD_W-1:0] prod;

  // shared units
  logic                     mul_start;
  logic signed [WORD_W-1:0] mul_a, mul_b, mul_p;
  stat_t                    mstat;
  logic                     div_start;
  logic [MOMENT_W-1:0]      dquot;
  stat_t                    dstat;

  // per-axis selection
  logic [POWER_W-1:0]         cur_p;
  logic [IDX_W-1:0]           p_idx;
  logic [SIZE_W-1:0]          cur_size;
  logic signed [OFFSET_W-1:0] cur_off;
  logic [WORD_W-1:0]          half;
  logic signed [WORD_W-1:0]   d_ext;
  logic [IDX_W-1:0]           pa_idx, pb_idx;
  logic signed [WORD_W-1:0]   pa_rd, pb_rd;
  logic [WORD_W:0]            add_sum;
  logic                       add_ovf;
  logic signed [WORD_W-1:0]   add_res;
  logic [POWER_W-1:0]         in_px, in_py, in_pz;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == S_IDLE);

  always_comb begin
    in_px = clamp_deg(s_axis_tdata[2:0]);
    in_py = clamp_deg(s_axis_tdata[5:3]);
    in_pz = clamp_deg(s_axis_tdata[8:6]);

    case (axis)
      2'd0: begin
        cur_p = pw_x; cur_size = size_x; cur_off = off_x;
      end
      2'd1: begin
        cur_p = pw_y; cur_size = size_y; cur_off = off_y;
      end
      default: begin
        cur_p = pw_z; cur_size = size_z; cur_off = off_z;
      end
    endcase
    p_idx = IDX_W'(cur_p);
    half  = {34'd0, cur_size[SIZE_W-1:1]};    // h/2, low bit dropped
    d_ext = WORD_W'(cur_off);

    // one read port per power table
    pa_idx = (state == S_CROSS) ? IDX_W'(p_idx - m) : IDX_W'(k - IDX_W'(1));
    pb_idx = (state == S_CROSS) ? m : IDX_W'(k - IDX_W'(1));
    pa_rd  = pa[pa_idx];
    pb_rd  = pb[pb_idx];

    // saturating accumulate of a cross term
    add_sum = {sum[WORD_W-1], sum} + {mul_p[WORD_W-1], mul_p};
    add_ovf = add_sum[WORD_W] ^ add_sum[WORD_W-1];
    if (add_ovf) begin
      add_res = add_sum[WORD_W] ? WORD_MIN : WORD_MAX;
    end else begin
      add_res = add_sum[WORD_W-1:0];
    end

    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    case (state)
      S_POWA: begin
        mul_start = 1'b1; mul_a = pa_rd; mul_b = a_end;
      end
      S_POWB: begin
        mul_start = 1'b1; mul_a = pb_rd; mul_b = b_end;
      end
      S_CROSS: begin
        mul_start = 1'b1; mul_a = pa_rd; mul_b = pb_rd;
      end
      S_PXY: begin
        mul_start = 1'b1; mul_a = sx; mul_b = sy;
      end
      S_PZ: begin
        mul_start = 1'b1; mul_a = prod; mul_b = sum;
      end
      default: ;
    endcase
    div_start = (state == S_DIV);
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      size_x <= SIZE_W'(Q_ONE);
      size_y <= SIZE_W'(Q_ONE);
      size_z <= SIZE_W'(Q_ONE);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CELL_SIZE_X: size_x <= cfg_data;
        REG_CELL_SIZE_Y: size_y <= cfg_data;
        REG_CELL_SIZE_Z: size_z <= cfg_data;
        default: ;                         // unknown index: ignored
      endcase
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      m_axis_tvalid <= 1'b0;
    end else begin
      // S_OUT reloads the register itself when the waiting item leaves
      if (m_axis_tvalid && m_axis_tready && state != S_OUT) m_axis_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            pw_x    <= in_px;
            pw_y    <= in_py;
            pw_z    <= in_pz;
            off_x   <= s_axis_tdata[40:9];
            off_y   <= s_axis_tdata[72:41];
            off_z   <= s_axis_tdata[104:73];
            divisor <= DIV_W'((int'(in_px) + 1) * (int'(in_py) + 1) * (int'(in_pz) + 1));
            axis    <= 2'd0;
            clip    <= 1'b0;
            state   <= S_AXIS;
          end
        end
        S_AXIS: begin
          a_end <= d_ext + half;
          b_end <= d_ext - half;
          pa[0] <= Q_ONE;
          pb[0] <= Q_ONE;
          sum   <= '0;
          k     <= IDX_W'(1);
          m     <= '0;
          state <= (cur_p == '0) ? S_CROSS : S_POWA;
        end
        S_POWA: begin
          op    <= OP_POWA;
          state <= S_MWAIT;
        end
        S_POWB: begin
          op    <= OP_POWB;
          state <= S_MWAIT;
        end
        S_CROSS: begin
          op    <= OP_CROSS;
          state <= S_MWAIT;
        end
        S_PXY: begin
          op    <= OP_PXY;
          state <= S_MWAIT;
        end
        S_PZ: begin
          op    <= OP_PZ;
          state <= S_MWAIT;
        end
        S_MWAIT: begin
          if (mstat.done) begin
            // a cross term can also clip in the accumulate
            clip <= clip | mstat.clip | ((op == OP_CROSS) && add_ovf);
            case (op)
              OP_POWA: begin
                pa[k] <= mul_p;
                state <= S_POWB;
              end
              OP_POWB: begin
                pb[k] <= mul_p;
                if (k == p_idx) begin
                  m     <= '0;
                  state <= S_CROSS;
                end else begin
                  k     <= k + IDX_W'(1);
                  state <= S_POWA;
                end
              end
              OP_CROSS: begin
                sum <= add_res;
                if (m == p_idx) begin
                  case (axis)
                    2'd0:    sx <= add_res;
                    2'd1:    sy <= add_res;
                    default: ;
                  endcase
                  if (axis == 2'd2) begin
                    state <= S_PXY;
                  end else begin
                    axis  <= axis + 2'd1;
                    state <= S_AXIS;
                  end
                end else begin
                  m     <= m + IDX_W'(1);
                  state <= S_CROSS;
                end
              end
              OP_PXY: begin
                prod  <= mul_p;
                state <= S_PZ;
              end
              OP_PZ: begin
                prod  <= mul_p;
                state <= S_DIV;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_DIV:   state <= S_DWAIT;
        S_DWAIT: begin
          if (dstat.done) state <= S_OUT;
        end
        S_OUT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid   <= 1'b1;
            m_axis_tdata    <= dquot;
            m_axis_tuser[0] <= clip | dstat.clip;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  ccm_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .op_a    (mul_a),
    .op_b    (mul_b),
    .product (mul_p),
    .stat    (mstat)
  );

  ccm_div #(
    .DIV_W (DIV_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod),
    .divisor  (divisor),
    .quot     (dquot),
    .stat     (dstat)
  );

endmodule

`default_nettype wire

// ===== rtl/ccm_check.sv =====
`default_nettype none

module ccm_check import ccm_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [MOMENT_W-1:0]   m_axis_tdata,
  input logic [0:0]            m_axis_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // one item at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second item taken while busy");

  // no result can appear on the cycle after an item is taken
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
    else $error("result appeared too early");

  // reset leaves the unit idle and empty
  a_reset: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid && s_axis_tready)
    else $error("not idle after reset");

endmodule

bind cartesian_cell_moment_unit ccm_check u_check (.*);

`default_nettype wire
